[src/mfq_pkg.sv]
// Shared types and constants of the multilevel feedback queue scheduler.
// Used by the core, the adder, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package mfq_pkg;

	localparam int CFG_IW = 3;
	localparam int NUM_SLICES = 5;

	localparam logic [CFG_IW-1:0] CFG_SLICE0 = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_SLICE1 = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_SLICE2 = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_SLICE3 = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_SLICE4 = 3'd4;

	localparam logic [15:0] SLICE0_RST = 16'd1;
	localparam logic [15:0] SLICE1_RST = 16'd2;
	localparam logic [15:0] SLICE2_RST = 16'd4;
	localparam logic [15:0] SLICE3_RST = 16'd8;
	localparam logic [15:0] SLICE4_RST = 16'd16;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  job_id;
		logic [31:0] arrival_time;
		logic [15:0] service_need;
	} job_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  done_id;
		logic [31:0] done_time;
		logic [31:0] turnaround;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] arrival;
		logic [15:0] remaining;
	} entry_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_req_t;

	typedef logic [NUM_SLICES-1:0][15:0] slices_t;

endpackage

[src/mfq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the job queues; depends on nothing.
`timescale 1ns / 1ps

module mfq_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/mfq_alu.sv]
// Shared 32-bit add and subtract unit with carry out.
// Depends on mfq_pkg for the request struct.
`timescale 1ns / 1ps

module mfq_alu (
	input  mfq_pkg::alu_req_t req,
	output logic [32:0]       sum
);

	always_comb begin
		if (req.sub) begin
			sum = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			sum = {1'b0, req.a} + {1'b0, req.b};
		end
	end

endmodule

[src/mfq_core.sv]
// Scheduling sequencer: queue bookkeeping, quantum steps and the result buffers.
// Depends on mfq_pkg; drives the job RAM and the shared adder from outside.
`timescale 1ns / 1ps

module mfq_core #(
	parameter int LEVELS = 5,
	parameter int JOB_CAPACITY = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     job_valid,
	output logic                                     job_stall,
	input  mfq_pkg::job_t                            job,
	output logic                                     res_valid,
	input  logic                                     res_stall,
	output mfq_pkg::res_t                            res,
	input  mfq_pkg::slices_t                         slices,
	output mfq_pkg::alu_req_t                        alu_req,
	input  logic [32:0]                              alu_sum,
	output logic                                     ram_we,
	output logic [$clog2(LEVELS*JOB_CAPACITY)-1:0]   ram_waddr,
	output mfq_pkg::entry_t                          ram_wdata,
	output logic [$clog2(LEVELS*JOB_CAPACITY)-1:0]   ram_raddr,
	input  mfq_pkg::entry_t                          ram_rdata
);

	localparam int LW = $clog2(LEVELS);
	localparam int IW = $clog2(JOB_CAPACITY);
	localparam int CW = $clog2(JOB_CAPACITY + 1);
	localparam int AW = $clog2(LEVELS * JOB_CAPACITY);
	localparam logic [AW-1:0] CAP_A = AW'(JOB_CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(JOB_CAPACITY);
	localparam logic [CW:0] CAP_T = (CW+1)'(JOB_CAPACITY);
	localparam logic [IW-1:0] LAST_IDX = IW'(JOB_CAPACITY - 1);
	localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_PICK   = 13'b0000000000010,
		S_POP    = 13'b0000000000100,
		S_LOAD   = 13'b0000000001000,
		S_RMIN   = 13'b0000000010000,
		S_RLIM   = 13'b0000000100000,
		S_ADV    = 13'b0000001000000,
		S_REM    = 13'b0000010000000,
		S_TURN   = 13'b0000100000000,
		S_EMIT   = 13'b0001000000000,
		S_PUSH   = 13'b0010000000000,
		S_ADMIT  = 13'b0100000000000,
		S_FINISH = 13'b1000000000000
	} state_t;

	state_t                state_q;
	logic                  cmd_q;
	logic [7:0]            id_q;
	logic [31:0]           arr_q;
	logic [15:0]           need_q;
	logic [31:0]           ct_q;
	logic [CW-1:0]         active_q;
	logic [IW-1:0]         heads_q [LEVELS];
	logic [CW-1:0]         counts_q [LEVELS];
	logic [LW-1:0]         lvl_q;
	mfq_pkg::entry_t       job_q;
	logic [15:0]           r_q;
	logic                  hit_q;
	logic [31:0]           limit_q;
	logic                  lt_q;
	logic                  bounded_q;
	logic                  admit_q;
	logic                  done_after_q;
	mfq_pkg::res_t         new_q;
	logic                  pend_v_q;
	mfq_pkg::res_t         pend_q;
	logic                  out_v_q;
	mfq_pkg::res_t         out_q;

	logic                  found;
	logic [LW-1:0]         top;
	logic [2:0]            sidx;
	logic [15:0]           slice_raw;
	logic [15:0]           slice;
	logic                  borrow;
	logic                  out_free;
	logic [LW-1:0]         dst;
	logic [CW:0]           tail_sum;
	logic [IW-1:0]         tail_idx;

	always_comb begin
		found = 1'b0;
		top = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (counts_q[l] != '0) begin
				found = 1'b1;
				top = LW'(l);
			end
		end
	end

	always_comb begin
		sidx = (int'(lvl_q) < 4) ? 3'(lvl_q) : 3'd4;
		slice_raw = slices[sidx];
		slice = (slice_raw == 16'd0) ? 16'd1 : slice_raw;
	end

	always_comb begin
		if (!hit_q) begin
			dst = lvl_q;
		end else if (lvl_q == LAST_LVL) begin
			dst = lvl_q;
		end else begin
			dst = lvl_q + LW'(1);
		end
		tail_sum = (CW+1)'(heads_q[dst]) + (CW+1)'(counts_q[dst]);
		if (tail_sum >= CAP_T) begin
			tail_idx = IW'(tail_sum - CAP_T);
		end else begin
			tail_idx = IW'(tail_sum);
		end
	end

	always_comb begin
		alu_req = '{a: arr_q, b: ct_q, sub: 1'b1};
		case (state_q)
			S_RMIN: alu_req = '{a: {16'd0, job_q.remaining}, b: {16'd0, slice}, sub: 1'b1};
			S_RLIM: alu_req = '{a: limit_q, b: {16'd0, r_q}, sub: 1'b1};
			S_ADV:  alu_req = '{a: ct_q, b: {16'd0, r_q}, sub: 1'b0};
			S_REM:  alu_req = '{a: {16'd0, job_q.remaining}, b: {16'd0, r_q}, sub: 1'b1};
			S_TURN: alu_req = '{a: ct_q, b: job_q.arrival, sub: 1'b1};
			default: alu_req = '{a: arr_q, b: ct_q, sub: 1'b1};
		endcase
	end

	assign borrow = alu_sum[32];
	assign out_free = !out_v_q || !res_stall;
	assign job_stall = (state_q != S_IDLE);
	assign res_valid = out_v_q;
	assign res = out_q;

	assign ram_raddr = AW'(top) * CAP_A + AW'(heads_q[top]);
	assign ram_waddr = AW'(dst) * CAP_A + AW'(tail_idx);
	assign ram_wdata = job_q;
	assign ram_we = (state_q == S_PUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ct_q <= '0;
			active_q <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				heads_q[l] <= '0;
				counts_q[l] <= '0;
			end
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
			admit_q <= 1'b0;
			bounded_q <= 1'b0;
			done_after_q <= 1'b0;
		end else begin
			if (out_v_q && !res_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						cmd_q <= job.cmd;
						id_q <= job.job_id;
						arr_q <= job.arrival_time;
						need_q <= job.service_need;
						bounded_q <= (job.cmd == mfq_pkg::CMD_ARRIVE);
						admit_q <= 1'b0;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					limit_q <= alu_sum[31:0];
					lt_q <= !borrow && (alu_sum[31:0] != 32'd0);
					if (cmd_q == mfq_pkg::CMD_DRAIN) begin
						if (found) begin
							state_q <= S_POP;
						end else begin
							new_q <= '{status: mfq_pkg::ST_DRAIN, done_id: 8'd0,
								done_time: ct_q, turnaround: 32'd0, last: 1'b0};
							done_after_q <= 1'b1;
							state_q <= S_EMIT;
						end
					end else if (!borrow && (alu_sum[31:0] != 32'd0) && found) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_ADMIT;
					end
				end
				S_POP: begin
					lvl_q <= top;
					heads_q[top] <= (heads_q[top] == LAST_IDX) ? '0 : heads_q[top] + IW'(1);
					counts_q[top] <= counts_q[top] - CW'(1);
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					job_q <= ram_rdata;
					state_q <= S_RMIN;
				end
				S_RMIN: begin
					r_q <= borrow ? job_q.remaining : slice;
					hit_q <= !borrow;
					state_q <= bounded_q ? S_RLIM : S_ADV;
				end
				S_RLIM: begin
					if (borrow) begin
						r_q <= limit_q[15:0];
						hit_q <= 1'b0;
					end
					state_q <= S_ADV;
				end
				S_ADV: begin
					ct_q <= alu_sum[31:0];
					state_q <= S_REM;
				end
				S_REM: begin
					job_q.remaining <= alu_sum[15:0];
					state_q <= (alu_sum[15:0] == 16'd0) ? S_TURN : S_PUSH;
				end
				S_TURN: begin
					if (active_q != '0) begin
						active_q <= active_q - CW'(1);
					end
					new_q <= '{status: mfq_pkg::ST_DONE, done_id: job_q.id,
						done_time: ct_q, turnaround: alu_sum[31:0], last: 1'b0};
					done_after_q <= admit_q;
					state_q <= S_EMIT;
				end
				S_PUSH: begin
					if (counts_q[dst] < CAP_C) begin
						counts_q[dst] <= counts_q[dst] + CW'(1);
					end
					state_q <= admit_q ? S_FINISH : S_PICK;
				end
				S_ADMIT: begin
					if (active_q >= CAP_C) begin
						new_q <= '{status: mfq_pkg::ST_REJECT, done_id: id_q,
							done_time: ct_q, turnaround: 32'd0, last: 1'b0};
						done_after_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						if (lt_q) begin
							ct_q <= arr_q;
						end
						active_q <= active_q + CW'(1);
						job_q <= '{id: id_q, arrival: arr_q, remaining: need_q};
						lvl_q <= '0;
						bounded_q <= 1'b0;
						admit_q <= 1'b1;
						state_q <= S_RMIN;
					end
				end
				S_EMIT: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_q <= pend_q;
							out_v_q <= 1'b1;
						end
						pend_q <= new_q;
						pend_v_q <= 1'b1;
						state_q <= done_after_q ? S_FINISH : S_PICK;
					end
				end
				S_FINISH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q <= pend_q;
						out_q.last <= 1'b1;
						out_v_q <= 1'b1;
						pend_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= CAP_C)
		else $error("active job count exceeds capacity");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("result left pending while idle");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> found)
		else $error("pop from empty queues");

endmodule

[src/multilevel_feedback_queue_scheduler.sv]
// A job is one arrival or drain command; a sequencer works it through a shared 32-bit
// adder, one step per cycle while the result output does not stall it. Each queued
// quantum run while time advances, or during a drain, reads the queue from RAM, compares
// with the slice and, for an arrival, the limit, updates time and remaining, then completes
// or requeues the job. No new command is taken until all results of the current one are
// transferred or buffered.
// Depends on mfq_pkg, mfq_core, mfq_alu and mfq_ram.
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler #(
	parameter int LEVELS = 5,
	parameter int JOB_CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_stall,
	input  mfq_pkg::job_t               job,
	output logic                        res_valid,
	input  logic                        res_stall,
	output mfq_pkg::res_t               res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mfq_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [15:0]                 cfg_data
);

	localparam int AW = $clog2(LEVELS * JOB_CAPACITY);

	mfq_pkg::slices_t    slices_q;
	mfq_pkg::alu_req_t   alu_req;
	logic [32:0]         alu_sum;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [AW-1:0]       ram_raddr;
	mfq_pkg::entry_t     ram_wdata;
	mfq_pkg::entry_t     ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slices_q[0] <= mfq_pkg::SLICE0_RST;
			slices_q[1] <= mfq_pkg::SLICE1_RST;
			slices_q[2] <= mfq_pkg::SLICE2_RST;
			slices_q[3] <= mfq_pkg::SLICE3_RST;
			slices_q[4] <= mfq_pkg::SLICE4_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mfq_pkg::CFG_SLICE0: slices_q[0] <= cfg_data;
				mfq_pkg::CFG_SLICE1: slices_q[1] <= cfg_data;
				mfq_pkg::CFG_SLICE2: slices_q[2] <= cfg_data;
				mfq_pkg::CFG_SLICE3: slices_q[3] <= cfg_data;
				mfq_pkg::CFG_SLICE4: slices_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	mfq_core #(
		.LEVELS(LEVELS),
		.JOB_CAPACITY(JOB_CAPACITY)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.job(job),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.slices(slices_q),
		.alu_req(alu_req),
		.alu_sum(alu_sum),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	mfq_alu u_alu (
		.req(alu_req),
		.sum(alu_sum)
	);

	mfq_ram #(
		.WIDTH($bits(mfq_pkg::entry_t)),
		.DEPTH(LEVELS * JOB_CAPACITY)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

[tb/multilevel_feedback_queue_scheduler_test.sv]
// Self-checking testbench of the multilevel feedback queue scheduler: directed and random
// arrivals and drains under several slice settings, checked against an in-bench predictor.
// Depends on mfq_pkg and multilevel_feedback_queue_scheduler.
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler_test;

	localparam int LVLS = 5;
	localparam int CAP = 16;
	localparam int MAX_RES = 17;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic job_valid;
	logic job_stall;
	mfq_pkg::job_t job;
	logic res_valid;
	logic res_stall;
	mfq_pkg::res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [mfq_pkg::CFG_IW-1:0] cfg_index;
	logic [15:0] cfg_data;

	multilevel_feedback_queue_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_stall(job_stall), .job(job),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mfq_pkg::job_t pending_jobs[$];
	mfq_pkg::res_t expected_results[$];

	mfq_pkg::entry_t level_q[LVLS][$];
	logic [31:0] sched_time;
	int queued_jobs;
	logic [15:0] slice_reg[LVLS];
	int step_results;

	int idle_pct;
	int mismatches;
	int jobs_sent;
	int results_seen;
	int phases;
	int quiet_cycles;
	logic [31:0] next_arrival;

	function automatic logic [31:0] slice_for(int lvl);
		logic [15:0] s;
		s = slice_reg[lvl > 4 ? 4 : lvl];
		return (s == 16'd0) ? 32'd1 : {16'd0, s};
	endfunction

	function automatic void add_result(logic [1:0] st, logic [7:0] id, logic [31:0] fin,
			logic [31:0] turn);
		mfq_pkg::res_t r;
		if (step_results >= MAX_RES)
			return;
		r.status = st;
		r.done_id = id;
		r.done_time = fin;
		r.turnaround = turn;
		r.last = 1'b0;
		expected_results.push_back(r);
		step_results++;
	endfunction

	function automatic int busiest_level();
		for (int l = 0; l < LVLS; l++)
			if (level_q[l].size() != 0)
				return l;
		return -1;
	endfunction

	function automatic void run_quantum(int lvl, mfq_pkg::entry_t e, bit bounded,
			logic [31:0] lim);
		logic [31:0] s;
		logic [31:0] r;
		s = slice_for(lvl);
		r = ({16'd0, e.remaining} < s) ? {16'd0, e.remaining} : s;
		if (bounded && lim < r)
			r = lim;
		sched_time = sched_time + r;
		e.remaining = e.remaining - r[15:0];
		if (e.remaining == 16'd0) begin
			if (queued_jobs > 0)
				queued_jobs--;
			add_result(mfq_pkg::ST_DONE, e.id, sched_time, sched_time - e.arrival);
		end else if (r == s) begin
			level_q[(lvl + 1 < LVLS) ? lvl + 1 : lvl].push_back(e);
		end else begin
			level_q[lvl].push_back(e);
		end
	endfunction

	function automatic void predict_job(mfq_pkg::job_t j);
		int lvl;
		mfq_pkg::entry_t e;
		step_results = 0;
		if (j.cmd == mfq_pkg::CMD_DRAIN) begin
			lvl = busiest_level();
			while (lvl >= 0) begin
				run_quantum(lvl, level_q[lvl].pop_front(), 1'b0, 32'd0);
				lvl = busiest_level();
			end
			add_result(mfq_pkg::ST_DRAIN, 8'd0, sched_time, 32'd0);
		end else begin
			lvl = busiest_level();
			while (sched_time < j.arrival_time && lvl >= 0) begin
				run_quantum(lvl, level_q[lvl].pop_front(), 1'b1,
					j.arrival_time - sched_time);
				lvl = busiest_level();
			end
			if (queued_jobs >= CAP) begin
				add_result(mfq_pkg::ST_REJECT, j.job_id, sched_time, 32'd0);
			end else begin
				e.id = j.job_id;
				e.arrival = j.arrival_time;
				e.remaining = j.service_need;
				if (sched_time < j.arrival_time)
					sched_time = j.arrival_time;
				queued_jobs++;
				run_quantum(0, e, 1'b0, 32'd0);
			end
		end
		if (step_results > 0)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endfunction

	task automatic queue_arrival(logic [7:0] id, logic [31:0] gap, logic [15:0] need);
		mfq_pkg::job_t j;
		next_arrival = next_arrival + gap;
		j.cmd = mfq_pkg::CMD_ARRIVE;
		j.job_id = id;
		j.arrival_time = next_arrival;
		j.service_need = need;
		pending_jobs.push_back(j);
	endtask

	task automatic queue_drain();
		mfq_pkg::job_t j;
		j.cmd = mfq_pkg::CMD_DRAIN;
		j.job_id = 8'($urandom);
		j.arrival_time = $urandom;
		j.service_need = 16'($urandom);
		pending_jobs.push_back(j);
	endtask

	task automatic write_slice(logic [mfq_pkg::CFG_IW-1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		slice_reg[idx] = val;
	endtask

	task automatic set_slices(logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
			logic [15:0] s3, logic [15:0] s4);
		write_slice(mfq_pkg::CFG_SLICE0, s0);
		write_slice(mfq_pkg::CFG_SLICE1, s1);
		write_slice(mfq_pkg::CFG_SLICE2, s2);
		write_slice(mfq_pkg::CFG_SLICE3, s3);
		write_slice(mfq_pkg::CFG_SLICE4, s4);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_items(int n, int max_need);
		int k;
		int burst;
		k = 0;
		while (k < n) begin
			case ($urandom_range(99)) inside
				[0:7]: begin
					queue_drain();
					k++;
				end
				[8:13]: begin
					burst = $urandom_range(4, 18);
					for (int b = 0; b < burst; b++)
						queue_arrival(8'($urandom), 32'd0, 16'($urandom_range(max_need)));
					k += burst;
				end
				[14:16]: begin
					queue_arrival(8'($urandom), 32'($urandom_range(1 << 20)),
						16'($urandom_range(max_need)));
					k++;
				end
				default: begin
					queue_arrival(8'($urandom), 32'($urandom_range(40)),
						16'($urandom_range(max_need)));
					k++;
				end
			endcase
		end
	endtask

	task automatic finish_phase();
		while (pending_jobs.size() != 0 || job_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		phases++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (job_valid && !job_stall) begin
			predict_job(job);
			jobs_sent++;
		end
		if (!job_valid || !job_stall) begin
			if (pending_jobs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				job <= pending_jobs.pop_front();
				job_valid <= 1'b1;
			end else begin
				job_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		mfq_pkg::res_t want;
		if (arst_n)
			res_stall <= ($urandom_range(99) < idle_pct);
		if (res_valid && !res_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", res);
			end else begin
				want = expected_results.pop_front();
				if (res.status !== want.status || res.done_id !== want.done_id ||
						res.done_time !== want.done_time ||
						res.turnaround !== want.turnaround || res.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, res);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((job_valid && !job_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		job_valid = 1'b0;
		job = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 28;
		mismatches = 0;
		jobs_sent = 0;
		results_seen = 0;
		phases = 0;
		quiet_cycles = 0;
		next_arrival = 32'd0;
		sched_time = 32'd0;
		queued_jobs = 0;
		slice_reg[0] = mfq_pkg::SLICE0_RST;
		slice_reg[1] = mfq_pkg::SLICE1_RST;
		slice_reg[2] = mfq_pkg::SLICE2_RST;
		slice_reg[3] = mfq_pkg::SLICE3_RST;
		slice_reg[4] = mfq_pkg::SLICE4_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_arrival(8'd0, 32'd0, 16'd0);
		queue_arrival(8'd255, 32'd0, 16'd1);
		queue_arrival(8'd1, 32'd3, 16'd5);
		queue_arrival(8'd2, 32'd0, 16'd2);
		for (int i = 0; i < 17; i++)
			queue_arrival(8'(16 + i), 32'd0, 16'd10);
		queue_arrival(8'd3, 32'd2, 16'd4);
		queue_drain();
		finish_phase();

		set_slices(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_arrival(8'hAA, 32'd5, 16'hFFFF);
		queue_arrival(8'h55, 32'd7, 16'h8000);
		queue_arrival(8'h0F, 32'd70000, 16'd100);
		queue_drain();
		random_items(12, 65535);
		queue_drain();
		finish_phase();

		set_slices(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_items(20, 40);
		queue_drain();
		finish_phase();

		idle_pct = 0;
		set_slices(16'd3, 16'd1, 16'd5, 16'd2, 16'd7);
		random_items(20, 60);
		queue_drain();
		finish_phase();

		idle_pct = 28;
		set_slices(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
			16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
			16'($urandom_range(1, 20)));
		random_items(20, 80);
		if (next_arrival < 32'hFFFF_FF00)
			next_arrival = 32'hFFFF_FF00;
		queue_arrival(8'h81, 32'd0, 16'd300);
		queue_arrival(8'h7E, 32'd200, 16'd40);
		queue_drain();
		finish_phase();

		if (expected_results.size() != 0)
			mismatches++;
		$display("Ran %0d commands in %0d slice settings, checked %0d results.",
			jobs_sent, phases, results_seen);
		$display("Stimulus covered rejections, drains, zero slices and time wraparound.");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
